FILE: sv/som_pkg.sv
// ----------------------------------------------------------------------------
// som_pkg
// shared types, constants and codes of the 2d self-organising map core
// ----------------------------------------------------------------------------
package som_pkg;

  localparam int GRID_ROWS  = 10;
  localparam int GRID_COLS  = 10;
  localparam int UNIT_COUNT = GRID_ROWS * GRID_COLS;
  localparam int ROW_W      = $clog2(GRID_ROWS);
  localparam int COL_W      = $clog2(GRID_COLS);
  localparam int CMP_W      = 8;

  // squared grid distances run from zero to the far corner
  localparam int HT_DEPTH = (GRID_ROWS - 1) * (GRID_ROWS - 1)
                          + (GRID_COLS - 1) * (GRID_COLS - 1) + 1;
  localparam int HT_AW    = $clog2(HT_DEPTH);

  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [16:0] LR_RESET    = 17'd13107;
  localparam logic [16:0] DECAY_RESET = 17'd30004;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TRAIN = 2'd1;

  localparam logic [1:0] CFG_LEARNING_RATE  = 2'd0;
  localparam logic [1:0] CFG_NEIGHBOR_DECAY = 2'd1;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  unit_row;
    logic [3:0]  unit_col;
    logic [15:0] sample_x;
    logic [15:0] sample_y;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  winner_row;
    logic [3:0]  winner_col;
    logic [32:0] min_distance;
    logic [15:0] weight_x;
    logic [15:0] weight_y;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_SEARCH,
    ST_PRE,
    ST_UPDATE
  } som_state_t;

endpackage

FILE: sv/som_2d_training_step_core.sv
// ----------------------------------------------------------------------------
// som_2d_training_step_core
// 2d self-organising map: load, read and train one request at a time
// ----------------------------------------------------------------------------
// The unit weights live in a ring of GRID_ROWS*GRID_COLS cells that rotates
// one place per cycle, while a request is worked, past a single processing
// element, so every request costs whole rotations of the ring. A load or read
// takes one rotation up to the result strobe; a train takes one rotation for
// the winner search, one state to prime the neighbourhood table read and one
// rotation for the update. After reset and after every register write the
// neighbourhood table is rebuilt, with busy high: a start step, then one
// multiply per entry. The result strobe out_valid lasts one cycle and cannot
// be held off, so the receiver must take out_res in that cycle; busy falls in
// the same cycle, so a new request may be started then.
// ----------------------------------------------------------------------------
module som_2d_training_step_core
  import som_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_valid,
  output out_res_t    out_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  // squared grid distance between two units, as table address
  function automatic logic [HT_AW-1:0] grid_dist(logic [ROW_W-1:0] r,
                                                 logic [COL_W-1:0] c,
                                                 logic [ROW_W-1:0] br,
                                                 logic [COL_W-1:0] bc);
    logic [ROW_W-1:0]   dr;
    logic [COL_W-1:0]   dc;
    logic [2*ROW_W+2*COL_W:0] s;
    dr = (r >= br) ? (r - br) : (br - r);
    dc = (c >= bc) ? (c - bc) : (bc - c);
    s  = (2*ROW_W+2*COL_W+1)'(dr) * (2*ROW_W+2*COL_W+1)'(dr)
       + (2*ROW_W+2*COL_W+1)'(dc) * (2*ROW_W+2*COL_W+1)'(dc);
    return s[HT_AW-1:0];
  endfunction

  som_state_t       state_r, state_nxt;
  in_req_t          req_r, req_nxt;
  out_res_t         res_r, res_nxt;
  logic             valid_r, valid_nxt;
  logic [ROW_W-1:0] hr_r, hr_nxt, nr;
  logic [COL_W-1:0] hc_r, hc_nxt, nc;
  logic [ROW_W-1:0] br_r, br_nxt;
  logic [COL_W-1:0] bc_r, bc_nxt;
  logic [32:0]      min_r, min_nxt;
  logic [16:0]      lr_r, decay_r;
  logic             build_r;

  logic             accept;
  logic             last;
  logic             match;
  logic             shift;
  logic [31:0]      tail;
  logic [31:0]      ring_q [UNIT_COUNT];
  logic [31:0]      head;
  logic [32:0]      sq_dist;
  logic [31:0]      upd;
  logic [16:0]      alpha, decay;
  logic [16:0]      h;
  logic [HT_AW-1:0] rd_addr;
  logic             tab_ready;

  // ---- configuration registers, table rebuilt on any write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= LR_RESET;
      decay_r <= DECAY_RESET;
      build_r <= 1'b1;
    end else begin
      build_r <= cfg_we;
      if (cfg_we && cfg_index == CFG_LEARNING_RATE) begin
        lr_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_NEIGHBOR_DECAY) begin
        decay_r <= cfg_data;
      end
    end
  end

  // values above one take part as one
  assign alpha = (lr_r > ONE_Q16) ? ONE_Q16 : lr_r;
  assign decay = (decay_r > ONE_Q16) ? ONE_Q16 : decay_r;

  som_htab u_htab (
    .clk     (clk),
    .rst_n   (rst_n),
    .build   (build_r),
    .alpha   (alpha),
    .decay   (decay),
    .rd_addr (rd_addr),
    .rd_data (h),
    .ready   (tab_ready)
  );

  // ---- ring of unit cells, cell 0 is the head, the tail takes the pe output in update
  for (genvar i = 0; i < UNIT_COUNT; i++) begin : g_ring
    if (i == UNIT_COUNT - 1) begin : g_tail
      som_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d(tail),
                       .q(ring_q[i]));
    end else begin : g_mid
      som_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d(ring_q[i+1]),
                       .q(ring_q[i]));
    end
  end

  assign head = ring_q[0];

  som_pe u_pe (
    .w       (head),
    .sx      (req_r.sample_x),
    .sy      (req_r.sample_y),
    .h       (h),
    .sq_dist (sq_dist),
    .upd     (upd)
  );

  // ---- head position and the one after it (table lookahead), wraps at the end
  assign last  = (hr_r == ROW_W'(GRID_ROWS - 1)) && (hc_r == COL_W'(GRID_COLS - 1));
  assign nr    = (hc_r == COL_W'(GRID_COLS - 1)) ? (last ? '0 : hr_r + 1'b1) : hr_r;
  assign nc    = (hc_r == COL_W'(GRID_COLS - 1)) ? '0 : hc_r + 1'b1;
  assign match = (CMP_W'(hr_r) == CMP_W'(req_r.unit_row))
              && (CMP_W'(hc_r) == CMP_W'(req_r.unit_col));

  assign busy   = (state_r != ST_IDLE) || !tab_ready;
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    valid_nxt = 1'b0;
    hr_nxt    = hr_r;
    hc_nxt    = hc_r;
    br_nxt    = br_r;
    bc_nxt    = bc_r;
    min_nxt   = min_r;
    shift     = 1'b0;
    tail      = head;
    rd_addr   = grid_dist(nr, nc, br_r, bc_r);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt            = in_req;
          res_nxt.winner_row = in_req.unit_row;
          res_nxt.winner_col = in_req.unit_col;
          res_nxt.min_distance = '0;
          res_nxt.weight_x   = '0;
          res_nxt.weight_y   = '0;
          hr_nxt             = '0;
          hc_nxt             = '0;
          state_nxt          = (in_req.action == ACT_TRAIN) ? ST_SEARCH : ST_PASS;
        end
      end
      // load or read: one rotation, act on the addressed unit
      ST_PASS: begin
        shift = 1'b1;
        if (match) begin
          if (req_r.action == ACT_LOAD) begin
            tail = {req_r.sample_y, req_r.sample_x};
          end
          res_nxt.weight_x = tail[15:0];
          res_nxt.weight_y = tail[31:16];
        end
        hr_nxt = nr;
        hc_nxt = nc;
        if (last) begin
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      // winner search, first unit in row-major order keeps ties
      ST_SEARCH: begin
        shift = 1'b1;
        if ((hr_r == '0 && hc_r == '0) || sq_dist < min_r) begin
          min_nxt = sq_dist;
          br_nxt  = hr_r;
          bc_nxt  = hc_r;
        end
        hr_nxt = nr;
        hc_nxt = nc;
        if (last) begin
          state_nxt = ST_PRE;
        end
      end
      // prime the table read for the first unit
      ST_PRE: begin
        rd_addr   = grid_dist('0, '0, br_r, bc_r);
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        shift = 1'b1;
        tail  = upd;
        if (hr_r == br_r && hc_r == bc_r) begin
          res_nxt.winner_row   = 4'(br_r);
          res_nxt.winner_col   = 4'(bc_r);
          res_nxt.min_distance = min_r;
          res_nxt.weight_x     = upd[15:0];
          res_nxt.weight_y     = upd[31:16];
        end
        hr_nxt = nr;
        hc_nxt = nc;
        if (last) begin
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    req_r <= req_nxt;
    res_r <= res_nxt;
    hr_r  <= hr_nxt;
    hc_r  <= hc_nxt;
    br_r  <= br_nxt;
    bc_r  <= bc_nxt;
    min_r <= min_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: sv/som_cell.sv
// ----------------------------------------------------------------------------
// som_cell
// one map unit: holds a weight pair and hands it on along the ring
// ----------------------------------------------------------------------------
module som_cell
  import som_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        shift,
  input  logic [31:0] d,
  output logic [31:0] q
);

  logic [31:0] w_r;
  logic [31:0] w_nxt;

  assign w_nxt = shift ? d : w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
    end else begin
      w_r <= w_nxt;
    end
  end

  assign q = w_r;

endmodule

FILE: sv/som_pe.sv
// ----------------------------------------------------------------------------
// som_pe
// processing element at the ring head: distance to sample and weight update
// ----------------------------------------------------------------------------
module som_pe
  import som_pkg::*;
(
  input  logic [31:0] w,
  input  logic [15:0] sx,
  input  logic [15:0] sy,
  input  logic [16:0] h,
  output logic [32:0] sq_dist,
  output logic [31:0] upd
);

  function automatic logic [31:0] sq_diff(logic [15:0] a, logic [15:0] b);
    logic [15:0] dd;
    dd = (a > b) ? (a - b) : (b - a);
    return 32'(dd) * 32'(dd);
  endfunction

  // w + floor(h * (s - w) / 2^16), clamped
  function automatic logic [15:0] move_toward(logic [15:0] wv, logic [15:0] s,
                                              logic [16:0] hv);
    logic signed [16:0] diff;
    logic signed [34:0] prod;
    logic signed [18:0] delta;
    logic signed [19:0] r;
    diff  = $signed({1'b0, s}) - $signed({1'b0, wv});
    prod  = $signed({1'b0, hv}) * diff;
    delta = prod[34:16];
    r     = $signed({4'b0, wv}) + $signed({delta[18], delta});
    if (r < 0) begin
      return 16'd0;
    end else if (r > 20'sd65535) begin
      return 16'hffff;
    end else begin
      return r[15:0];
    end
  endfunction

  assign sq_dist = {1'b0, sq_diff(w[15:0], sx)} + {1'b0, sq_diff(w[31:16], sy)};
  assign upd     = {move_toward(w[31:16], sy, h), move_toward(w[15:0], sx, h)};

endmodule

FILE: sv/som_htab.sv
// ----------------------------------------------------------------------------
// som_htab
// neighbourhood table: rate times decay to the power of squared distance
// ----------------------------------------------------------------------------
module som_htab
  import som_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             build,
  input  logic [16:0]      alpha,
  input  logic [16:0]      decay,
  input  logic [HT_AW-1:0] rd_addr,
  output logic [16:0]      rd_data,
  output logic             ready
);

  logic [16:0]      mem [HT_DEPTH];
  logic [16:0]      rd_r;
  logic [16:0]      h_r, h_nxt;
  logic [HT_AW-1:0] idx_r, idx_nxt;
  logic             run_r, run_nxt;
  logic [33:0]      prod;

  // truncated q1.16 product, zero stays zero
  assign prod = 34'(h_r) * 34'(decay);

  always_comb begin
    h_nxt   = h_r;
    idx_nxt = idx_r;
    run_nxt = run_r;
    if (build) begin
      h_nxt   = alpha;
      idx_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      h_nxt   = prod[32:16];
      idx_nxt = idx_r + 1'b1;
      if (idx_r == HT_AW'(HT_DEPTH - 1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      idx_r <= '0;
    end else begin
      run_r <= run_nxt;
      idx_r <= idx_nxt;
    end
    h_r <= h_nxt;
  end

  always_ff @(posedge clk) begin
    if (run_r && !build) begin
      mem[idx_r] <= h_r;
    end
    rd_r <= mem[rd_addr];
  end

  assign rd_data = rd_r;
  assign ready   = !run_r && !build;

endmodule

FILE: sv/som_chk.sv
// ----------------------------------------------------------------------------
// som_chk
// port-level checks of the map core, bound to the top level
// ----------------------------------------------------------------------------
module som_chk
  import som_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // table rebuild follows reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("request accepted but core not working");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind som_2d_training_step_core som_chk u_som_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 2d self-organising map training core
// ----------------------------------------------------------------------------
// Requests (load, read, train) go in through the start/busy port. A model of
// the map held here predicts each result. Results are compared field by field
// in order. Register writes happen only once the core has gone quiet.
// ----------------------------------------------------------------------------
module tb_top;
  import som_pkg::*;

  // read codes not named in the package
  localparam logic [1:0] ACT_READ     = 2'd2;
  localparam logic [1:0] ACT_READ_ALT = 2'd3;
  // register indexes that decode to nothing
  localparam logic [1:0] CFG_SPARE_A  = 2'd2;
  localparam logic [1:0] CFG_SPARE_B  = 2'd3;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 2 * UNIT_COUNT + 20;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_req_t     in_req;
  logic        out_valid;
  out_res_t    out_res;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  som_2d_training_step_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // map state as the bench believes it to be
  logic [31:0] map_weights [UNIT_COUNT];
  logic [16:0] rate_reg;
  logic [16:0] decay_reg;

  out_res_t pending_results [$];
  int       error_count;
  int       idle_cycles;
  int       load_count, train_count, read_count, result_count;
  int       burst_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // w + floor(h*(s-w)/65536), held to 16 bits
  function automatic logic [15:0] step_toward(logic [15:0] w, logic [15:0] s,
                                              logic [16:0] h);
    longint diff, prod, delta, r;
    diff = longint'(s) - longint'(w);
    prod = longint'(h) * diff;
    if (prod >= 0) delta = prod >>> 16;
    else delta = -(((-prod) + 65535) >>> 16);
    r = longint'(w) + delta;
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return r[15:0];
  endfunction

  function automatic longint sq_gap(logic [15:0] a, logic [15:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  // apply one request to the local map and return the result it must give
  function automatic out_res_t map_apply(in_req_t req);
    out_res_t    res;
    logic [16:0] alpha, decay, h;
    longint      best, d;
    int          br, bc, idx, dr, dc, grid_sq;
    logic [31:0] w;
    res = '0;
    if (req.action == ACT_TRAIN) begin
      alpha = (rate_reg > ONE_Q16) ? ONE_Q16 : rate_reg;
      decay = (decay_reg > ONE_Q16) ? ONE_Q16 : decay_reg;
      best = -1;
      br = 0;
      bc = 0;
      // winner search, first in row-major order keeps a tie
      for (int r = 0; r < GRID_ROWS; r++)
        for (int c = 0; c < GRID_COLS; c++) begin
          w = map_weights[r * GRID_COLS + c];
          d = sq_gap(w[15:0], req.sample_x) + sq_gap(w[31:16], req.sample_y);
          if (best < 0 || d < best) begin
            best = d;
            br = r;
            bc = c;
          end
        end
      for (int r = 0; r < GRID_ROWS; r++)
        for (int c = 0; c < GRID_COLS; c++) begin
          dr = r - br;
          dc = c - bc;
          grid_sq = dr * dr + dc * dc;
          h = alpha;
          for (int k = 0; k < grid_sq && h != 0; k++)
            h = 17'((longint'(h) * longint'(decay)) >> 16);
          idx = r * GRID_COLS + c;
          w = map_weights[idx];
          map_weights[idx] = {step_toward(w[31:16], req.sample_y, h),
                              step_toward(w[15:0], req.sample_x, h)};
        end
      w = map_weights[br * GRID_COLS + bc];
      res.winner_row   = 4'(br);
      res.winner_col   = 4'(bc);
      res.min_distance = 33'(best);
      res.weight_x     = w[15:0];
      res.weight_y     = w[31:16];
    end else begin
      res.winner_row = req.unit_row;
      res.winner_col = req.unit_col;
      if (int'(req.unit_row) < GRID_ROWS && int'(req.unit_col) < GRID_COLS) begin
        idx = int'(req.unit_row) * GRID_COLS + int'(req.unit_col);
        if (req.action == ACT_LOAD) map_weights[idx] = {req.sample_y, req.sample_x};
        res.weight_x = map_weights[idx][15:0];
        res.weight_y = map_weights[idx][31:16];
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // checking and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    out_res_t want;
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or result for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
      if (out_valid) begin
        result_count++;
        if (pending_results.size() == 0) begin
          $display("[%0t] result with no request outstanding", $realtime);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_res.winner_row !== want.winner_row)
            report_mismatch("winner_row", longint'(out_res.winner_row),
                            longint'(want.winner_row));
          if (out_res.winner_col !== want.winner_col)
            report_mismatch("winner_col", longint'(out_res.winner_col),
                            longint'(want.winner_col));
          if (out_res.min_distance !== want.min_distance)
            report_mismatch("min_distance", longint'(out_res.min_distance),
                            longint'(want.min_distance));
          if (out_res.weight_x !== want.weight_x)
            report_mismatch("weight_x", longint'(out_res.weight_x),
                            longint'(want.weight_x));
          if (out_res.weight_y !== want.weight_y)
            report_mismatch("weight_y", longint'(out_res.weight_y),
                            longint'(want.weight_y));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // one request: held until taken, then dropped at the next falling edge
  task automatic send_request(logic [1:0] act, logic [3:0] row, logic [3:0] col,
                              logic [15:0] sx, logic [15:0] sy);
    in_req_t req;
    // bursty sender: random gaps between runs of requests
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 300)) @(negedge clk);
    end
    burst_left--;
    req = '{action: act, unit_row: row, unit_col: col, sample_x: sx, sample_y: sy};
    @(negedge clk);
    in_req = req;
    start  = 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(map_apply(req));
    case (act)
      ACT_LOAD:  load_count++;
      ACT_TRAIN: train_count++;
      default:   read_count++;
    endcase
    @(negedge clk);
    start  = 1'b0;
    in_req = in_req_t'({$urandom, $urandom});
  endtask

  // hold off until every outstanding result is back
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [16:0] value);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    if (idx == CFG_LEARNING_RATE) rate_reg = value;
    else if (idx == CFG_NEIGHBOR_DECAY) decay_reg = value;
  endtask

  function automatic logic [15:0] rand_q16();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, every action and the corner cases
  task automatic test_directed();
    send_request(ACT_READ, 4'd0, 4'd0, 16'h0, 16'h0);        // cleared at reset
    send_request(ACT_TRAIN, 4'd0, 4'd0, 16'h0, 16'h0);       // all units tie
    send_request(ACT_TRAIN, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF);
    send_request(ACT_LOAD, 4'd0, 4'd0, 16'hFFFF, 16'h0000);
    send_request(ACT_LOAD, 4'd9, 4'd9, 16'h0000, 16'hFFFF);
    send_request(ACT_LOAD, 4'd9, 4'd0, 16'hFFFF, 16'hFFFF);
    send_request(ACT_READ, 4'd0, 4'd0, 16'h1234, 16'h5678);
    send_request(ACT_READ_ALT, 4'd9, 4'd9, 16'h0, 16'h0);   // action three reads
    send_request(ACT_LOAD, 4'd10, 4'd3, 16'hAAAA, 16'h5555); // off the grid, dropped
    send_request(ACT_LOAD, 4'd2, 4'd15, 16'hAAAA, 16'h5555);
    send_request(ACT_READ, 4'd15, 4'd15, 16'h0, 16'h0);      // off grid reads zero
    send_request(ACT_READ, 4'd3, 4'd12, 16'h0, 16'h0);
    send_request(ACT_TRAIN, 4'd15, 4'd15, 16'hFFFF, 16'h0000);
    send_request(ACT_TRAIN, 4'd0, 4'd0, 16'h0000, 16'hFFFF);
    send_request(ACT_TRAIN, 4'd0, 4'd0, 16'h8000, 16'h8000);
    send_request(ACT_READ, 4'd9, 4'd0, 16'h0, 16'h0);
    send_request(ACT_READ_ALT, 4'd0, 4'd9, 16'h0, 16'h0);
  endtask

  // a few trains under each register setting, extremes included
  task automatic test_registers();
    logic [16:0] rates  [6] = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd40000, LR_RESET};
    logic [16:0] decays [6] = '{17'd0, 17'd65536, 17'h1FFFF, 17'd65535, 17'd1, DECAY_RESET};
    for (int s = 0; s < 6; s++) begin
      write_register(CFG_LEARNING_RATE, rates[s]);
      write_register(CFG_NEIGHBOR_DECAY, decays[s]);
      // spare indexes must leave both registers alone
      write_register((s % 2) ? CFG_SPARE_A : CFG_SPARE_B, 17'($urandom));
      send_request(ACT_LOAD, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                   rand_q16(), rand_q16());
      for (int i = 0; i < 5; i++)
        send_request(ACT_TRAIN, 4'($urandom), 4'($urandom), rand_q16(), rand_q16());
      send_request(ACT_READ, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                   16'h0, 16'h0);
    end
  endtask

  // random map set-ups followed by long training runs
  task automatic test_random(int total);
    int sent;
    int pick;
    sent = 0;
    for (int phase = 0; sent < total; phase++) begin
      // fresh registers between phases, usually inside the valid range
      write_register(CFG_LEARNING_RATE, ($urandom_range(0, 7) == 0) ?
                     17'($urandom) : 17'($urandom_range(0, 65536)));
      write_register(CFG_NEIGHBOR_DECAY, ($urandom_range(0, 7) == 0) ?
                     17'($urandom) : 17'($urandom_range(20000, 65536)));
      // seed a handful of units so the search has something to find
      repeat ($urandom_range(5, 20)) begin
        send_request(ACT_LOAD, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                     rand_q16(), rand_q16());
        sent++;
      end
      repeat ($urandom_range(40, 90)) begin
        pick = $urandom_range(0, 9);
        if (pick < 7)
          send_request(ACT_TRAIN, 4'($urandom), 4'($urandom), rand_q16(), rand_q16());
        else if (pick == 7)
          send_request(ACT_LOAD, 4'($urandom), 4'($urandom), rand_q16(), rand_q16());
        else
          send_request(2'($urandom_range(2, 3)), 4'($urandom), 4'($urandom),
                       16'($urandom), 16'($urandom));
        sent++;
      end
      // on even phases the sender holds back until the core has emptied
      if (phase % 2 == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req      = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_LEARNING_RATE;
    cfg_data    = '0;
    error_count = 0;
    idle_cycles = 0;
    burst_left  = 0;
    load_count  = 0;
    train_count = 0;
    read_count  = 0;
    result_count = 0;
    rate_reg    = LR_RESET;
    decay_reg   = DECAY_RESET;
    foreach (map_weights[i]) map_weights[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_registers();
    test_random(750);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d loads, %0d trains, %0d reads; %0d results checked",
             load_count, train_count, read_count, result_count);
    $display("register sweep took in zero, one, above one and random rates and decays");
    if (error_count == 0 && pending_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
